// ===== sv/hsd_pkg.sv =====
// hsd_pkg: constants, register codes and fixed-point helpers for the haversine distance block.
// No dependencies; used by hsd_trig, hsd_sqrt and haversine_sphere_distance.
package hsd_pkg;

	localparam int ANGLE_FRAC_BITS = 30;
	localparam int TRIG_ITERATIONS = 32;
	// Taylor terms past the seventh always truncate to zero for |r| <= pi/2 at this precision
	localparam int TAYLOR_TERMS    = 7;
	localparam int TRIG_LAT        = 6 + 2 * TAYLOR_TERMS + 1;
	localparam int SQRT_BITS       = (ANGLE_FRAC_BITS + 62) / 2 + 1;
	localparam int ZW              = 34;

	localparam int ADDR_W = 3;
	localparam logic REG_RADIUS = 1'b0;
	localparam logic [23:0] RADIUS_RST = 24'd6378137;

	localparam logic [63:0] PI60   = 64'h3243F6A8885A308D;
	localparam logic [95:0] DEGK_W = {PI60, 32'd0} / 96'd1800000000;
	localparam logic [63:0] DEGK   = DEGK_W[63:0];
	localparam logic [63:0] PI_Q   = (PI60 + (64'd1 << (59 - ANGLE_FRAC_BITS)))
		>> (60 - ANGLE_FRAC_BITS);
	localparam logic [63:0] HP_Q   = (PI60 + (64'd1 << (60 - ANGLE_FRAC_BITS)))
		>> (61 - ANGLE_FRAC_BITS);
	localparam logic [34:0] OUT_MAX = 35'h7FFFFFFFF;

	function automatic logic [67:0] rndf(input logic [67:0] x);
		return (x + (68'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
	endfunction

	function automatic longint div_odd(input longint x, input int k);
		case (k)
			0:  return x;
			1:  return x / 3;
			2:  return x / 5;
			3:  return x / 7;
			4:  return x / 9;
			5:  return x / 11;
			6:  return x / 13;
			7:  return x / 15;
			8:  return x / 17;
			9:  return x / 19;
			10: return x / 21;
			11: return x / 23;
			12: return x / 25;
			13: return x / 27;
			14: return x / 29;
			15: return x / 31;
			16: return x / 33;
			17: return x / 35;
			18: return x / 37;
			19: return x / 39;
			20: return x / 41;
			21: return x / 43;
			22: return x / 45;
			23: return x / 47;
			24: return x / 49;
			25: return x / 51;
			26: return x / 53;
			27: return x / 55;
			28: return x / 57;
			29: return x / 59;
			30: return x / 61;
			default: return 64'sd0;
		endcase
	endfunction

	// atan(2^-i) at 2^-62 (pi/4 from PI60 for i = 0, else the truncated alternating series), rounded to Q(F)
	function automatic logic [ZW-1:0] atan_q(input int i);
		longint acc;
		longint term;
		int sh;
		acc = 0;
		if (i == 0) begin
			acc = longint'(PI60);
		end else begin
			for (int k = 0; k < 31; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= 62) begin
					term = div_odd(longint'(64'd1 << (62 - sh)), k);
					acc = ((k & 1) != 0) ? acc - term : acc + term;
				end
			end
		end
		return ZW'((acc + (longint'(1) << (61 - ANGLE_FRAC_BITS))) >>> (62 - ANGLE_FRAC_BITS));
	endfunction

endpackage

// ===== sv/hsd_trig.sv =====
// hsd_trig: angle scaling, range fold and Taylor series for one sine or cosine.
// Depends on hsd_pkg; hsd_pkg::TRIG_LAT pipeline stages, advancing on adv.
module hsd_trig #(
	parameter bit HALF    = 1'b0,
	parameter bit COS_OUT = 1'b0
) (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [32:0] v,
	output logic signed [31:0] y
);

	localparam int F  = hsd_pkg::ANGLE_FRAC_BITS;
	localparam int T  = hsd_pkg::TAYLOR_TERMS;
	localparam int SH = 92 - F + int'(HALF);
	localparam int AW = 35;
	localparam int RW = F + 1;
	localparam int QW = F + 2;
	localparam logic signed [AW-1:0] PI_S  = AW'(hsd_pkg::PI_Q);
	localparam logic signed [AW-1:0] PI2_S = AW'(hsd_pkg::PI_Q << 1);
	localparam logic signed [AW-1:0] HP_S  = AW'(hsd_pkg::HP_Q);
	localparam logic [RW-1:0] ONE_R = RW'(1) << F;

	logic              vneg_s1;
	logic [31:0]       vmag_s1;
	logic              vneg_s2;
	logic [63:0]       plo_s2, phi_s2;
	logic signed [AW-1:0] ang_s3;
	logic              rneg_s4, flip_s4;
	logic [RW-1:0]     rmag_s4;
	logic              rneg_s5, flip_s5;
	logic [RW-1:0]     rmag_s5;
	logic [2*RW-1:0]   r2p_s5;
	logic              rneg_s6, flip_s6;
	logic [QW-1:0]     r2_s6;
	logic [63:0]       p_s6;
	logic signed [33:0] acc_s6;

	logic [65:0]        prod_sa [1:T];
	logic signed [33:0] acc_sa  [1:T];
	logic [QW-1:0]      r2_sa   [1:T];
	logic               rneg_sa [1:T];
	logic               flip_sa [1:T];
	logic signed [33:0] acc_sb  [1:T];
	logic [63:0]        p_sb    [1:T];
	logic [QW-1:0]      r2_sb   [1:T];
	logic               rneg_sb [1:T];
	logic               flip_sb [1:T];
	logic signed [31:0] y_sc;

	logic [95:0]          sum96;
	logic [95:0]          amag;
	logic signed [AW-1:0] amag_s;
	logic signed [AW-1:0] red;
	logic signed [AW-1:0] fold;
	logic                 flip_c;
	logic [QW-1:0]        r2_c;
	logic [RW-1:0]        t0_c;

	always_comb begin
		sum96  = {phi_s2, 32'd0} + {32'd0, plo_s2};
		amag   = (sum96 + (96'd1 << (SH - 1))) >> SH;
		amag_s = AW'(amag);
	end

	always_comb begin
		if (ang_s3 > PI_S) begin
			red = ang_s3 - PI2_S;
		end else if (ang_s3 < -PI_S) begin
			red = ang_s3 + PI2_S;
		end else begin
			red = ang_s3;
		end
		flip_c = 1'b1;
		if (red > HP_S) begin
			fold = PI_S - red;
		end else if (red < -HP_S) begin
			fold = -PI_S - red;
		end else begin
			fold   = red;
			flip_c = 1'b0;
		end
	end

	always_comb begin
		r2_c = QW'(hsd_pkg::rndf(68'(r2p_s5)));
		t0_c = COS_OUT ? ONE_R : rmag_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vneg_s1 <= v[32];
			vmag_s1 <= v[32] ? 32'(-v) : 32'(v);
			vneg_s2 <= vneg_s1;
			plo_s2  <= 64'(vmag_s1) * 64'(hsd_pkg::DEGK[31:0]);
			phi_s2  <= 64'(vmag_s1) * 64'(hsd_pkg::DEGK[63:32]);
			ang_s3  <= vneg_s2 ? -amag_s : amag_s;
			rneg_s4 <= fold[AW-1];
			rmag_s4 <= fold[AW-1] ? RW'(-fold) : RW'(fold);
			flip_s4 <= flip_c;
			rneg_s5 <= rneg_s4;
			flip_s5 <= flip_s4;
			rmag_s5 <= rmag_s4;
			r2p_s5  <= (2*RW)'(rmag_s4) * (2*RW)'(rmag_s4);
			rneg_s6 <= rneg_s5;
			flip_s6 <= flip_s5;
			r2_s6   <= r2_c;
			p_s6    <= 64'(t0_c) * 64'(r2_c);
			acc_s6  <= $signed(34'(t0_c));
		end
	end

	for (genvar k = 1; k <= T; k++) begin : g_term
		localparam int D = COS_OUT ? (2 * k - 1) * (2 * k) : (2 * k) * (2 * k + 1);
		localparam int L = $clog2(D);
		localparam int S = 32 + L;
		localparam logic [33:0] MAGIC =
			34'(((longint'(1) << S) + longint'(D) - 1) / longint'(D));

		logic [63:0]        p_in;
		logic signed [33:0] acc_in;
		logic [QW-1:0]      r2_in;
		logic               rneg_in, flip_in;
		logic [31:0]        m;
		logic [31:0]        q;

		if (k == 1) begin : g_first
			assign p_in    = p_s6;
			assign acc_in  = acc_s6;
			assign r2_in   = r2_s6;
			assign rneg_in = rneg_s6;
			assign flip_in = flip_s6;
		end else begin : g_next
			assign p_in    = p_sb[k-1];
			assign acc_in  = acc_sb[k-1];
			assign r2_in   = r2_sb[k-1];
			assign rneg_in = rneg_sb[k-1];
			assign flip_in = flip_sb[k-1];
		end

		assign m = 32'(hsd_pkg::rndf(68'(p_in)));
		assign q = 32'(prod_sa[k] >> S);

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_sa[k] <= 66'(m) * 66'(MAGIC);
				acc_sa[k]  <= acc_in;
				r2_sa[k]   <= r2_in;
				rneg_sa[k] <= rneg_in;
				flip_sa[k] <= flip_in;
				acc_sb[k]  <= ((k & 1) != 0) ? acc_sa[k] - $signed({2'b00, q})
					: acc_sa[k] + $signed({2'b00, q});
				p_sb[k]    <= 64'(q) * 64'(r2_sa[k]);
				r2_sb[k]   <= r2_sa[k];
				rneg_sb[k] <= rneg_sa[k];
				flip_sb[k] <= flip_sa[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (COS_OUT) begin
				y_sc <= flip_sb[T] ? 32'(-acc_sb[T]) : 32'(acc_sb[T]);
			end else begin
				y_sc <= rneg_sb[T] ? 32'(-acc_sb[T]) : 32'(acc_sb[T]);
			end
		end
	end

	assign y = y_sc;

endmodule

// ===== sv/hsd_sqrt.sv =====
// hsd_sqrt: floor square root of h * 2^62, one result bit per pipeline stage.
// Depends on hsd_pkg; hsd_pkg::SQRT_BITS pipeline stages, advancing on adv.
module hsd_sqrt (
	input  logic                           clk,
	input  logic                           adv,
	input  logic [hsd_pkg::ANGLE_FRAC_BITS:0] h,
	output logic [hsd_pkg::SQRT_BITS-1:0]  root
);

	localparam int QB = hsd_pkg::SQRT_BITS;
	localparam int W  = 2 * QB;

	logic [W-1:0] op_s  [0:QB-1];
	logic [W-1:0] res_s [0:QB-1];

	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam logic [W-1:0] ONE = W'(1) << (2 * (QB - 1 - j));
		logic [W-1:0] op_in, res_in, trial;

		if (j == 0) begin : g_first
			assign op_in  = W'(h) << 62;
			assign res_in = '0;
		end else begin : g_next
			assign op_in  = op_s[j-1];
			assign res_in = res_s[j-1];
		end

		assign trial = res_in + ONE;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (op_in >= trial) begin
					op_s[j]  <= op_in - trial;
					res_s[j] <= (res_in >> 1) + ONE;
				end else begin
					op_s[j]  <= op_in;
					res_s[j] <= res_in >> 1;
				end
			end
		end
	end

	assign root = QB'(res_s[QB-1]);

endmodule

// ===== sv/haversine_sphere_distance.sv =====
// haversine_sphere_distance: great-circle distance in millimetres between two points.
// Depends on hsd_pkg, hsd_trig (four instances) and hsd_sqrt (two instances).
//
//   channel   handshake                    payload
//   pair      pair_valid / pair_ready      first_lon, first_lat, second_lon, second_lat
//   dist      dist_valid / dist_ready      distance_mm
//   config    psel/penable/pwrite, pready  paddr, pwdata, prdata (sphere_radius_m)
//
// One pair per cycle while pair_ready is high; a transfer passes through 105 stages, the
// first loaded by the transfer (21 trig, 3 for h, 47 square root bits, 32 CORDIC steps,
// 2 for the radius scale), then the output register, which raises dist_valid.
// Reset clears the valid chain and output valid and loads the default radius.
// A waiting result stalls the pipeline only once its last stage holds valid data.
module haversine_sphere_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pair_valid,
	output logic                        pair_ready,
	input  logic signed [31:0]          first_lon,
	input  logic signed [30:0]          first_lat,
	input  logic signed [31:0]          second_lon,
	input  logic signed [30:0]          second_lat,
	output logic                        dist_valid,
	input  logic                        dist_ready,
	output logic [34:0]                 distance_mm,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int F   = hsd_pkg::ANGLE_FRAC_BITS;
	localparam int N   = hsd_pkg::TRIG_ITERATIONS;
	localparam int QB  = hsd_pkg::SQRT_BITS;
	localparam int ZW  = hsd_pkg::ZW;
	localparam int CW  = QB + 3;
	localparam int LAT = hsd_pkg::TRIG_LAT + 3 + QB + N + 2;
	localparam logic signed [35:0] ONE_H = 36'sd1 <<< F;

	logic adv;
	logic [LAT-1:0] vld_s;
	logic dvalid_q;
	logic [34:0] dmm_q;
	logic [23:0] radius_q;
	logic [33:0] rk_q;

	logic signed [32:0] dlat, dlon, lat1x, lat2x;
	logic signed [31:0] sa, sb, c1, c2;

	assign dlat  = {{2{first_lat[30]}}, first_lat} - {{2{second_lat[30]}}, second_lat};
	assign dlon  = {first_lon[31], first_lon} - {second_lon[31], second_lon};
	assign lat1x = {{2{first_lat[30]}}, first_lat};
	assign lat2x = {{2{second_lat[30]}}, second_lat};

	assign adv        = ~vld_s[LAT-1] | ~dvalid_q | dist_ready;
	assign pair_ready = adv;

	hsd_trig #(.HALF(1'b1), .COS_OUT(1'b0)) u_sa (.clk(clk), .adv(adv), .v(dlat),  .y(sa));
	hsd_trig #(.HALF(1'b1), .COS_OUT(1'b0)) u_sb (.clk(clk), .adv(adv), .v(dlon),  .y(sb));
	hsd_trig #(.HALF(1'b0), .COS_OUT(1'b1)) u_c1 (.clk(clk), .adv(adv), .v(lat1x), .y(c1));
	hsd_trig #(.HALF(1'b0), .COS_OUT(1'b1)) u_c2 (.clk(clk), .adv(adv), .v(lat2x), .y(c2));

	logic [31:0] sa_m, sb_m, c1_m, c2_m;
	logic [63:0] sqa_s22, cc_s22, sqb_s22;
	logic        cneg_s22;
	logic [32:0] sa2_s23;
	logic [65:0] p_s23;
	logic        cneg_s23;
	logic [F:0]  h_s24, hx_s24;
	logic [32:0] c12_c, sb2_c;
	logic [35:0] tq;
	logic signed [35:0] hsum;
	logic [F:0]  h_c;

	assign sa_m = sa[31] ? 32'(-sa) : 32'(sa);
	assign sb_m = sb[31] ? 32'(-sb) : 32'(sb);
	assign c1_m = c1[31] ? 32'(-c1) : 32'(c1);
	assign c2_m = c2[31] ? 32'(-c2) : 32'(c2);

	always_comb begin
		c12_c = 33'(hsd_pkg::rndf(68'(cc_s22)));
		sb2_c = 33'(hsd_pkg::rndf(68'(sqb_s22)));
		tq    = 36'(hsd_pkg::rndf(68'(p_s23)));
		hsum  = $signed(36'(sa2_s23)) + (cneg_s23 ? -$signed(tq) : $signed(tq));
		if (hsum < 0) begin
			h_c = '0;
		end else if (hsum > ONE_H) begin
			h_c = (F+1)'(ONE_H);
		end else begin
			h_c = hsum[F:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqa_s22  <= 64'(sa_m) * 64'(sa_m);
			cc_s22   <= 64'(c1_m) * 64'(c2_m);
			sqb_s22  <= 64'(sb_m) * 64'(sb_m);
			cneg_s22 <= c1[31] ^ c2[31];
			sa2_s23  <= 33'(hsd_pkg::rndf(68'(sqa_s22)));
			p_s23    <= 66'(c12_c) * 66'(sb2_c);
			cneg_s23 <= cneg_s22;
			h_s24    <= h_c;
			hx_s24   <= (F+1)'(ONE_H) - h_c;
		end
	end

	logic [QB-1:0] ry, rx;

	hsd_sqrt u_sqrt_y (.clk(clk), .adv(adv), .h(h_s24),  .root(ry));
	hsd_sqrt u_sqrt_x (.clk(clk), .adv(adv), .h(hx_s24), .root(rx));

	logic signed [CW-1:0] cx_s [0:N-1];
	logic signed [CW-1:0] cy_s [0:N-1];
	logic signed [ZW-1:0] cz_s [0:N-1];

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] TAB = $signed(hsd_pkg::atan_q(i));
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;

		if (i == 0) begin : g_first
			assign xi = $signed(CW'(rx));
			assign yi = $signed(CW'(ry));
			assign zi = '0;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!yi[CW-1]) begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + TAB;
				end else begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - TAB;
				end
			end
		end
	end

	logic [ZW-2:0] zc;
	logic [ZW-1:0] z2;
	logic [50:0]   pa_s104, pb_s104;
	logic [34:0]   d_s105;
	logic [67:0]   dsum, dr;

	assign zc   = cz_s[N-1][ZW-1] ? '0 : cz_s[N-1][ZW-2:0];
	assign z2   = {zc, 1'b0};
	assign dsum = 68'(pa_s104) + (68'(pb_s104) << 17);
	assign dr   = hsd_pkg::rndf(dsum);

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s104 <= 51'(z2) * 51'(rk_q[16:0]);
			pb_s104 <= 51'(z2) * 51'(rk_q[33:17]);
			d_s105  <= (dr > 68'(hsd_pkg::OUT_MAX)) ? hsd_pkg::OUT_MAX : dr[34:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s    <= '0;
			dvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[LAT-2:0], pair_valid};
			end
			if (adv && vld_s[LAT-1]) begin
				dvalid_q <= 1'b1;
			end else if (dist_ready) begin
				dvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[LAT-1]) begin
			dmm_q <= d_s105;
		end
	end

	assign dist_valid  = dvalid_q;
	assign distance_mm = dmm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hsd_pkg::RADIUS_RST;
			rk_q     <= 34'(hsd_pkg::RADIUS_RST) * 34'd1000;
		end else if (psel && penable && pwrite && paddr[2] == hsd_pkg::REG_RADIUS) begin
			radius_q <= pwdata[23:0];
			rk_q     <= 34'(pwdata[23:0]) * 34'd1000;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == hsd_pkg::REG_RADIUS) ? {8'd0, radius_q} : 32'd0;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> (vld_s[LAT-1] && dist_valid && !dist_ready))
		else $error("pipeline stalled without a blocked result");
	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair_ready) |=> vld_s[0])
		else $error("accepted transfer missing from valid chain");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |=> $stable(vld_s))
		else $error("valid chain moved during stall");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dist_valid) |-> $past(vld_s[LAT-1]))
		else $error("result without a valid last stage");

endmodule
